/* sv/ffla_pkg.sv */
// Shared types for the frame free-list allocator.
// Request kinds and result status codes; no dependencies.
package ffla_pkg;

    typedef enum logic {
        CMD_ALLOCATE = 1'b0,
        CMD_RELEASE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_GRANTED  = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_RELEASED = 2'd2
    } t_status;

endpackage

/* sv/ffla_link_ram.sv */
// Link/owner table of the frame allocator: one write port, one read port,
// registered read data, read-first on address collision. No dependencies.
module ffla_link_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/frame_free_list_allocator_top.sv */
// Top level of the frame free-list allocator: request/result streams,
// head register and table control. Uses ffla_pkg and ffla_link_ram.
//
//  channel  | dir | tdata                                  | tuser
//  ---------+-----+----------------------------------------+------------------
//  s_axis   | in  | [7:0] owner, [15:8] frame_index        | [0] command
//  m_axis   | out | [7:0] granted_frame                    | [1:0] status
//
//  One request beat per cycle sustained while m_axis is not stalled; a
//  request is held in the input register, its result in the result register.
//  After reset a clearing pass writes entry i = i+1 through the table, one
//  entry per cycle, with s_axis_tready low until it ends.
//  A stalled result holds in the result register; the input register keeps
//  taking beats while the result register can drain in the same cycle.
module frame_free_list_allocator_top
    import ffla_pkg::*;
#(
    parameter int FRAMES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] owner, [15:8] frame_index
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] granted_frame
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    // Table index width, link width (must hold the FRAMES end mark) and
    // entry width (must also hold a full 8-bit owner id).
    localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int LW = $clog2(FRAMES + 1);
    localparam int DW = (LW > 8) ? LW : 8;

    // input register
    logic          r_in_valid;
    t_cmd          r_in_cmd;
    logic [7:0]    r_in_owner;
    logic [7:0]    r_in_frame;

    // result register
    logic          r_out_valid;
    t_status       r_out_status;
    logic [7:0]    r_out_frame;
    t_status       n_out_status;
    logic [7:0]    n_out_frame;

    // free list head and table control
    logic [DW-1:0] r_head;
    logic [DW-1:0] n_head;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_cnt;
    logic          r_fwd_hit;
    logic [DW-1:0] r_fwd_data;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;
    logic [DW-1:0] w_rdata;
    logic [DW-1:0] w_link;

    logic          w_out_free;
    logic          w_proc;
    logic          w_head_ok;
    logic          w_rel_ok;
    logic          w_s_beat;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_proc        = r_in_valid && w_out_free && !r_clr_busy;
    assign s_axis_tready = !r_clr_busy && (!r_in_valid || w_out_free);
    assign w_s_beat      = s_axis_tvalid && s_axis_tready;

    assign w_head_ok = (r_head < DW'(FRAMES));
    assign w_rel_ok  = (DW'(r_in_frame) < DW'(FRAMES));

    // Link of the current head: the table read issued last cycle at the then
    // next head, patched with last cycle's write when it hit the same entry.
    assign w_link = r_fwd_hit ? r_fwd_data : w_rdata;

    // Table write, head update and result for the item in the input register.
    always_comb begin
        n_head       = r_head;
        w_we         = 1'b0;
        w_waddr      = r_clr_cnt;
        w_wdata      = DW'(r_clr_cnt) + DW'(1);
        n_out_status = ST_RELEASED;
        n_out_frame  = 8'd0;
        if (r_clr_busy) begin
            w_we = 1'b1;
        end else if (w_proc) begin
            case (r_in_cmd)
                CMD_ALLOCATE: begin
                    if (w_head_ok) begin
                        // pop: entry takes the owner id, head follows the link
                        w_we         = 1'b1;
                        w_waddr      = AW'(r_head);
                        w_wdata      = DW'(r_in_owner);
                        n_head       = w_link;
                        n_out_status = ST_GRANTED;
                        n_out_frame  = r_head[7:0];
                    end else begin
                        n_out_status = ST_EMPTY;
                    end
                end
                CMD_RELEASE: begin
                    // push: no double-release check; out-of-range is a no-op
                    if (w_rel_ok) begin
                        w_we    = 1'b1;
                        w_waddr = AW'(r_in_frame);
                        w_wdata = r_head;
                        n_head  = DW'(r_in_frame);
                    end
                    n_out_status = ST_RELEASED;
                end
                default: begin
                    n_out_status = ST_RELEASED;
                end
            endcase
        end
    end

    // Always prefetch the link of next cycle's head. An out-of-range head
    // aliases some entry; its link is never used.
    assign w_raddr = AW'(n_head);

    ffla_link_ram #(
        .DEPTH (FRAMES),
        .AW    (AW),
        .DW    (DW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_cnt   <= '0;
            r_fwd_hit   <= 1'b0;
        end else begin
            if (w_s_beat) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end

            if (w_proc) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(FRAMES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            r_head    <= n_head;
            r_fwd_hit <= w_we && (w_waddr == w_raddr);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_fwd_data <= w_wdata;
        if (w_s_beat) begin
            r_in_cmd   <= t_cmd'(s_axis_tuser);
            r_in_owner <= s_axis_tdata[7:0];
            r_in_frame <= s_axis_tdata[15:8];
        end
        if (w_proc) begin
            r_out_status <= n_out_status;
            r_out_frame  <= n_out_frame;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_frame;
    assign m_axis_tuser  = r_out_status;

    // No request is taken while the table is being cleared.
    a_no_beat_in_clear: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !s_axis_tready
    ) else $error("request beat accepted during clearing pass");

    // Results that are not grants carry a zero frame index.
    a_zero_frame: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_GRANTED)) |-> (r_out_frame == 8'd0)
    ) else $error("non-grant result with nonzero frame");

    // A refused allocate leaves the head untouched.
    a_refuse_keeps_head: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && (r_in_cmd == CMD_ALLOCATE) && !w_head_ok) |=> $stable(r_head)
    ) else $error("head moved on refused allocate");

    // A grant hands out the old head, and only when it was in range.
    a_grant_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && (n_out_status == ST_GRANTED)) |-> w_head_ok
    ) else $error("grant from an empty pool");

    // Table is written only by the clearing pass or by an item in process.
    a_write_source: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_clr_busy || w_proc)
    ) else $error("stray table write");

endmodule

/* verif/frame_free_list_allocator_top_tb.sv */
// Self-checking testbench for frame_free_list_allocator_top: drives request beats,
// predicts every result with a free-list model of its own and checks each result beat.
// Depends on ffla_pkg and the allocator RTL only.
module frame_free_list_allocator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffla_pkg::*;

    localparam int FRAMES       = 256;
    localparam int RANDOM_ITEMS = 1050;
    localparam int IDLE_LIMIT   = 2000;  // covers the clearing pass after reset
    localparam int N_DIRECTED   = 16;

    typedef struct {
        t_status    status;
        logic [7:0] frame;
    } t_frame_result;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] owner;
        logic [7:0] frame;
        bit         typed;      // expected result given in the row
        t_status    exp_status;
        logic [7:0] exp_frame;
    } t_request_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // [7:0] owner, [15:8] frame_index
    logic        s_axis_tuser;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] granted_frame
    logic [1:0]  m_axis_tuser;   // [1:0] status

    // Predicted allocator state: link while free, owner once granted.
    logic [8:0]    frame_links [FRAMES];
    logic [8:0]    free_head;
    t_frame_result results_due [$];
    logic [7:0]    held_frames [$];   // frames granted and not yet released
    int            beats_sent;
    int            error_count;
    int            idle_cycles;
    bit            quiet;             // no gaps on either side while set

    // Directed part. The rows touch no frame above 0xF0, so the tail of
    // the reset chain (entry 255 holding the end mark) survives for the first
    // pool drain of the random part.
    t_request_row directed_rows [N_DIRECTED] = '{
        '{CMD_ALLOCATE, 8'h00, 8'h00, 1'b1, ST_GRANTED,  8'h00},  // head after reset
        '{CMD_ALLOCATE, 8'hFF, 8'h00, 1'b1, ST_GRANTED,  8'h01},
        '{CMD_ALLOCATE, 8'hA5, 8'hFF, 1'b0, ST_GRANTED,  8'h00},
        '{CMD_RELEASE,  8'h5A, 8'h01, 1'b1, ST_RELEASED, 8'h00},
        '{CMD_ALLOCATE, 8'h5A, 8'h00, 1'b0, ST_GRANTED,  8'h00},  // reuses frame 1
        '{CMD_RELEASE,  8'h00, 8'h00, 1'b1, ST_RELEASED, 8'h00},
        '{CMD_RELEASE,  8'hFF, 8'h00, 1'b1, ST_RELEASED, 8'h00},  // double release: self loop
        '{CMD_ALLOCATE, 8'hF0, 8'h00, 1'b0, ST_GRANTED,  8'h00},
        '{CMD_ALLOCATE, 8'h0F, 8'h00, 1'b0, ST_GRANTED,  8'h00},  // owner becomes the head
        '{CMD_ALLOCATE, 8'hC3, 8'h00, 1'b0, ST_GRANTED,  8'h00},  // grants frame 0xF0
        '{CMD_RELEASE,  8'h3C, 8'hAA, 1'b1, ST_RELEASED, 8'h00},  // release of a free frame
        '{CMD_RELEASE,  8'hC3, 8'h55, 1'b1, ST_RELEASED, 8'h00},
        '{CMD_ALLOCATE, 8'h3C, 8'h00, 1'b0, ST_GRANTED,  8'h00},
        '{CMD_ALLOCATE, 8'h81, 8'h00, 1'b0, ST_GRANTED,  8'h00},
        '{CMD_RELEASE,  8'h7E, 8'h02, 1'b1, ST_RELEASED, 8'h00},
        '{CMD_ALLOCATE, 8'h42, 8'h00, 1'b0, ST_GRANTED,  8'h00}
    };

    frame_free_list_allocator_top #(
        .FRAMES(FRAMES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Pops the head on allocate, pushes the frame on release.
    function automatic void predict_frame_result(input t_cmd cmd, input logic [7:0] owner,
                                                 input logic [7:0] frame,
                                                 output t_frame_result res);
        logic [8:0] head;
        head = free_head;
        res.frame = 8'h00;
        if (cmd == CMD_ALLOCATE) begin
            if (head >= FRAMES) begin
                res.status = ST_EMPTY;
            end else begin
                free_head = frame_links[head];
                frame_links[head] = {1'b0, owner};
                res.status = ST_GRANTED;
                res.frame = head[7:0];
            end
        end else begin
            if (int'(frame) < FRAMES) begin
                frame_links[frame] = free_head;
                free_head = {1'b0, frame};
            end
            res.status = ST_RELEASED;
        end
    endfunction

    // Drives one request beat, waits for it to be taken, then books the
    // expected result. Call only right after a rising edge.
    task automatic issue_request(input t_cmd cmd, input logic [7:0] owner,
                                 input logic [7:0] frame, input bit typed = 1'b0,
                                 input t_status exp_status = ST_GRANTED,
                                 input logic [7:0] exp_frame = 8'h00);
        t_frame_result res;
        int            hit [$];
        if (!quiet && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {frame, owner};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_frame_result(cmd, owner, frame, res);
        if (typed) begin
            res.status = exp_status;
            res.frame  = exp_frame;
        end
        results_due.push_back(res);
        if (cmd == CMD_ALLOCATE && res.status == ST_GRANTED) begin
            held_frames.push_back(res.frame);
        end else if (cmd == CMD_RELEASE) begin
            hit = held_frames.find_first_index(x) with (x == frame);
            if (hit.size() != 0) held_frames.delete(hit[0]);
        end
        beats_sent++;
    endtask

    // Drops valid only when it is up, so a following request in the same
    // step is the only driver of valid there.
    task automatic wait_results_drained();
        if (s_axis_tvalid) begin
            s_axis_tvalid <= 1'b0;
        end
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: random back-pressure, none while quiet.
    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 18);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_frame_result due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (results_due.size() == 0) begin
                $error("result beat with nothing expected: status %0d granted_frame %0d",
                       m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                due = results_due.pop_front();
                if (m_axis_tuser !== due.status) begin
                    $error("status: expected %0d, actual %0d", due.status, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata !== due.frame) begin
                    $error("granted_frame: expected %0d, actual %0d", due.frame, m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: cycles in a row without a beat on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         kind;
        int         len;
        int         n;
        logic [7:0] f;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_ALLOCATE;
        m_axis_tready <= 1'b0;
        quiet       = 1'b0;
        beats_sent  = 0;
        error_count = 0;
        idle_cycles = 0;
        for (int i = 0; i < FRAMES; i++) frame_links[i] = 9'(i + 1);
        free_head = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            issue_request(directed_rows[i].cmd, directed_rows[i].owner,
                          directed_rows[i].frame, directed_rows[i].typed,
                          directed_rows[i].exp_status, directed_rows[i].exp_frame);
        end

        // Sender holds off until the pipeline is empty.
        wait_results_drained();

        // First drain walks the intact tail of the reset chain into an empty
        // pool, so refusals are seen before any later list damage.
        kind = 60;
        while (beats_sent < N_DIRECTED + RANDOM_ITEMS) begin
            quiet = (beats_sent >= 400 && beats_sent < 600);
            len = $urandom_range(1, 24);
            if (kind < 30) begin
                repeat (len) issue_request(CMD_ALLOCATE, 8'($urandom_range(255)),
                                           8'($urandom_range(255)));
            end else if (kind < 58) begin
                // mostly well-formed releases of frames still held
                repeat (len) begin
                    if (held_frames.size() != 0)
                        f = held_frames[$urandom_range(held_frames.size() - 1)];
                    else
                        f = 8'($urandom_range(255));
                    issue_request(CMD_RELEASE, 8'($urandom_range(255)), f);
                end
            end else if (kind < 70) begin
                // allocate until the pool runs dry, then a few refusals
                n = 0;
                while (n < 300 && free_head < FRAMES) begin
                    issue_request(CMD_ALLOCATE, 8'($urandom_range(255)),
                                  8'($urandom_range(255)));
                    n++;
                end
                repeat ($urandom_range(1, 4))
                    issue_request(CMD_ALLOCATE, 8'($urandom_range(255)),
                                  8'($urandom_range(255)));
            end else if (kind < 94) begin
                // noise: double releases, frames never granted, any owner
                repeat (len) issue_request(t_cmd'($urandom_range(1)), 8'($urandom_range(255)),
                                           8'($urandom_range(255)));
            end else begin
                wait_results_drained();
            end
            kind = $urandom_range(99);
        end
        quiet = 1'b0;

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/ffla_pkg.sv
sv/ffla_link_ram.sv
sv/frame_free_list_allocator_top.sv
verif/frame_free_list_allocator_top_tb.sv
